@@ rtl/core/sacl_pkg.sv @@
// ----------------------------------------------------------------------------
// sacl_pkg
// Shared types and codes of the set-associative LRU tag store.
// ----------------------------------------------------------------------------
package sacl_pkg;

  // request type codes
  localparam logic [1:0] REQ_LOAD   = 2'd0;
  localparam logic [1:0] REQ_STORE  = 2'd1;
  localparam logic [1:0] REQ_MODIFY = 2'd2;
  localparam logic [1:0] REQ_IFETCH = 2'd3;

  // configuration register indexes
  localparam logic [1:0] CFG_SET_BITS   = 2'd0;
  localparam logic [1:0] CFG_BLOCK_BITS = 2'd1;
  localparam logic [1:0] CFG_WAYS       = 2'd2;

  // reset values of the configuration registers
  localparam logic [2:0] SET_BITS_RST   = 3'd4;
  localparam logic [4:0] BLOCK_BITS_RST = 5'd4;
  localparam logic [3:0] WAYS_RST       = 4'd1;

  // raw set index before folding into the set count (set_bits is at most 7)
  localparam int RAW_SET_W = 7;
  localparam int RAW_SETS  = 128;

  typedef struct packed {
    logic [2:0] set_bits;
    logic [4:0] block_bits;
    logic [3:0] ways_in_use;
  } cfg_t;

  typedef struct packed {
    logic        valid;
    logic [63:0] tag;
    logic [31:0] stamp;
  } line_t;

  typedef struct packed {
    logic        first_hit;
    logic        evicted;
    logic        second_hit;
    logic [2:0]  way_used;
    logic [31:0] hits_total;
    logic [31:0] misses_total;
    logic [31:0] evictions_total;
  } res_t;

endpackage

@@ rtl/core/set_assoc_lru_cache_tags_top.sv @@
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_tags_top
// Set-associative cache tag store with LRU replacement and running totals.
// ----------------------------------------------------------------------------
// After reset the block sweeps its line memories one set per cycle with full
// held high. Requests then enter through a two-entry decode queue;
// instruction fetches are accepted and give no result. The lookup engine
// handles one request at a time: the set is read from the per-way memories
// as the request is taken, and in the lookup state all ways are compared; a
// hit or a fill into an invalid way updates the line and posts the result. A
// miss on a full set of more than one active way (ways_in_use with zero
// counted as one and capped at MAX_WAYS) goes on to the LRU victim search,
// which compares one stamp per cycle. A modify costs the same as a single
// lookup. Results wait in a two-entry queue, so the engine keeps going while
// pop is held low until that queue is full.
module set_assoc_lru_cache_tags_top import sacl_pkg::*; #(
  parameter int MAX_SETS = 64,
  parameter int MAX_WAYS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [4:0]  cfg_data,
  input  logic        in_push,
  output logic        in_full,
  input  logic [1:0]  in_req_type,
  input  logic [63:0] in_address,
  output logic        out_empty,
  input  logic        out_pop,
  output logic        out_first_hit,
  output logic        out_evicted,
  output logic        out_second_hit,
  output logic [2:0]  out_way_used,
  output logic [31:0] out_hits_total,
  output logic [31:0] out_misses_total,
  output logic [31:0] out_evictions_total
);

  localparam int SET_W = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;

  cfg_t             cfg_r;
  logic             clearing;
  logic             item_valid, item_take, item_modify;
  logic [63:0]      item_tag;
  logic [SET_W-1:0] item_set;
  logic             res_full, res_push;
  res_t             res_data, res_head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.set_bits    <= SET_BITS_RST;
      cfg_r.block_bits  <= BLOCK_BITS_RST;
      cfg_r.ways_in_use <= WAYS_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SET_BITS:   cfg_r.set_bits    <= cfg_data[2:0];
        CFG_BLOCK_BITS: cfg_r.block_bits  <= cfg_data;
        CFG_WAYS:       cfg_r.ways_in_use <= cfg_data[3:0];
        default: begin
        end
      endcase
    end
  end

  sacl_front #(.MAX_SETS(MAX_SETS)) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .hold        (clearing),
    .push        (in_push),
    .full        (in_full),
    .req_type    (in_req_type),
    .address     (in_address),
    .item_valid  (item_valid),
    .item_take   (item_take),
    .item_modify (item_modify),
    .item_tag    (item_tag),
    .item_set    (item_set)
  );

  sacl_back #(.MAX_SETS(MAX_SETS), .MAX_WAYS(MAX_WAYS)) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .clearing    (clearing),
    .item_valid  (item_valid),
    .item_take   (item_take),
    .item_modify (item_modify),
    .item_tag    (item_tag),
    .item_set    (item_set),
    .res_full    (res_full),
    .res_push    (res_push),
    .res_data    (res_data)
  );

  sacl_res_fifo u_res_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_push),
    .push_data (res_data),
    .full      (res_full),
    .empty     (out_empty),
    .pop       (out_pop),
    .pop_data  (res_head)
  );

  assign out_first_hit       = res_head.first_hit;
  assign out_evicted         = res_head.evicted;
  assign out_second_hit      = res_head.second_hit;
  assign out_way_used        = res_head.way_used;
  assign out_hits_total      = res_head.hits_total;
  assign out_misses_total    = res_head.misses_total;
  assign out_evictions_total = res_head.evictions_total;

endmodule

@@ rtl/core/sacl_front.sv @@
// ----------------------------------------------------------------------------
// sacl_front
// Request intake: drops instruction fetches, splits the address into tag and
// set, and holds decoded requests in a two-entry queue for the lookup engine.
// ----------------------------------------------------------------------------
module sacl_front import sacl_pkg::*; #(
  parameter int MAX_SETS = 64,
  localparam int SET_W = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  cfg_t             cfg,
  input  logic             hold,
  input  logic             push,
  output logic             full,
  input  logic [1:0]       req_type,
  input  logic [63:0]      address,
  output logic             item_valid,
  input  logic             item_take,
  output logic             item_modify,
  output logic [63:0]      item_tag,
  output logic [SET_W-1:0] item_set
);

  logic [SET_W-1:0]     set_tab [RAW_SETS];
  logic [5:0]           shift_amt;
  logic [63:0]          dec_tag;
  logic [63:0]          blk_shift;
  logic [RAW_SET_W-1:0] set_mask;
  logic [RAW_SET_W-1:0] set_raw;
  logic                 accept;
  logic                 enq;

  logic [1:0]       count_r, count_nxt;
  logic             wr_ptr_r, wr_ptr_nxt;
  logic             rd_ptr_r, rd_ptr_nxt;
  logic             q_modify_r [2];
  logic [63:0]      q_tag_r    [2];
  logic [SET_W-1:0] q_set_r    [2];

  // set index folds modulo the set count
  for (genvar g = 0; g < RAW_SETS; g++) begin : g_tab
    assign set_tab[g] = SET_W'(g % MAX_SETS);
  end

  always_comb begin
    shift_amt = {3'b000, cfg.set_bits} + {1'b0, cfg.block_bits};
    dec_tag   = address >> shift_amt;
    blk_shift = address >> cfg.block_bits;
    set_mask  = RAW_SET_W'((8'd1 << cfg.set_bits) - 8'd1);
    set_raw   = blk_shift[RAW_SET_W-1:0] & set_mask;
  end

  assign full   = (count_r == 2'd2) || hold;
  assign accept = push && !full;
  assign enq    = accept && (req_type != REQ_IFETCH);

  assign item_valid  = (count_r != 2'd0);
  assign item_modify = q_modify_r[rd_ptr_r];
  assign item_tag    = q_tag_r[rd_ptr_r];
  assign item_set    = q_set_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (enq) begin
      wr_ptr_nxt = !wr_ptr_r;
    end
    if (item_take) begin
      rd_ptr_nxt = !rd_ptr_r;
    end
    if (enq && !item_take) begin
      count_nxt = count_r + 2'd1;
    end else if (!enq && item_take) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= 2'd0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
    end else begin
      count_r  <= count_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (enq) begin
      q_modify_r[wr_ptr_r] <= (req_type == REQ_MODIFY);
      q_tag_r[wr_ptr_r]    <= dec_tag;
      q_set_r[wr_ptr_r]    <= set_tab[set_raw];
    end
  end

endmodule

@@ rtl/core/sacl_back.sv @@
// ----------------------------------------------------------------------------
// sacl_back
// Lookup engine: per-way line memories, hit and fill selection, serial LRU
// victim search, access clock and running totals.
// ----------------------------------------------------------------------------
module sacl_back import sacl_pkg::*; #(
  parameter int MAX_SETS = 64,
  parameter int MAX_WAYS = 8,
  localparam int SET_W = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1,
  localparam int WAY_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1,
  localparam int CNT_W = $clog2(MAX_WAYS + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  cfg_t             cfg,
  output logic             clearing,
  input  logic             item_valid,
  output logic             item_take,
  input  logic             item_modify,
  input  logic [63:0]      item_tag,
  input  logic [SET_W-1:0] item_set,
  input  logic             res_full,
  output logic             res_push,
  output res_t             res_data
);

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_LOOK  = 4'b0100,
    ST_SCAN  = 4'b1000
  } state_t;

  localparam logic [SET_W-1:0] LAST_ROW = SET_W'(MAX_SETS - 1);

  state_t state_r, state_nxt;
  logic [SET_W-1:0] row_r, row_nxt;
  logic             cur_modify_r;
  logic [63:0]      cur_tag_r;
  logic [SET_W-1:0] cur_set_r;
  logic [WAY_W-1:0] scan_idx_r, scan_idx_nxt;
  logic [WAY_W-1:0] victim_r, victim_nxt;
  logic [31:0]      best_r, best_nxt;
  logic [31:0]      clock_r, hits_r, misses_r, evicts_r;

  line_t            rd_line [MAX_WAYS];
  logic [MAX_WAYS-1:0] we;
  logic [SET_W-1:0] wr_addr;
  line_t            wr_data;

  logic [4:0]       ways_raw;
  logic [CNT_W-1:0] ways_act;
  logic [MAX_WAYS-1:0] match_vec, empty_vec;
  logic             any_hit, any_empty;
  logic [WAY_W-1:0] hit_way, empty_way;
  logic [31:0]      scan_stamp;
  logic             scan_lt, scan_last;

  logic             commit;
  logic [WAY_W-1:0] commit_way;
  logic             commit_hit, commit_evict;
  logic [31:0]      stamp_new, hits_new, misses_new, evicts_new;
  logic [WAY_W+2:0] way_ext;

  // per-way line memories, one row per set
  for (genvar w = 0; w < MAX_WAYS; w++) begin : g_way
    line_t line_mem [MAX_SETS];
    line_t rd_data_r;
    always_ff @(posedge clk) begin
      if (we[w]) begin
        line_mem[wr_addr] <= wr_data;
      end
      if (item_take) begin
        rd_data_r <= line_mem[item_set];
      end
    end
    assign rd_line[w] = rd_data_r;
  end

  // associativity: zero counts as one, saturates at the way count
  always_comb begin
    ways_raw = {1'b0, cfg.ways_in_use};
    if (ways_raw == 5'd0) begin
      ways_raw = 5'd1;
    end
    if (32'(ways_raw) > MAX_WAYS) begin
      ways_raw = 5'(MAX_WAYS);
    end
    ways_act = CNT_W'(ways_raw);
  end

  always_comb begin
    for (int i = 0; i < MAX_WAYS; i++) begin
      match_vec[i] = (i < int'(ways_act)) && rd_line[i].valid && (rd_line[i].tag == cur_tag_r);
      empty_vec[i] = (i < int'(ways_act)) && !rd_line[i].valid;
    end
    any_hit   = |match_vec;
    any_empty = |empty_vec;
    // lowest matching way, highest invalid way
    hit_way = '0;
    for (int i = MAX_WAYS - 1; i >= 0; i--) begin
      if (match_vec[i]) begin
        hit_way = WAY_W'(i);
      end
    end
    empty_way = '0;
    for (int i = 0; i < MAX_WAYS; i++) begin
      if (empty_vec[i]) begin
        empty_way = WAY_W'(i);
      end
    end
  end

  assign scan_stamp = rd_line[scan_idx_r].stamp;
  assign scan_lt    = scan_stamp < best_r;
  assign scan_last  = ({1'b0, scan_idx_r} == (WAY_W + 1)'(ways_act - CNT_W'(1)));

  assign clearing  = (state_r == ST_CLEAR);
  assign item_take = (state_r == ST_IDLE) && item_valid && !res_full;

  always_comb begin
    state_nxt    = state_r;
    row_nxt      = row_r;
    scan_idx_nxt = scan_idx_r;
    victim_nxt   = victim_r;
    best_nxt     = best_r;
    commit       = 1'b0;
    commit_way   = '0;
    commit_hit   = 1'b0;
    commit_evict = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        row_nxt = row_r + SET_W'(1);
        if (row_r == LAST_ROW) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (item_take) begin
          state_nxt = ST_LOOK;
        end
      end
      ST_LOOK: begin
        if (any_hit) begin
          commit     = 1'b1;
          commit_way = hit_way;
          commit_hit = 1'b1;
        end else if (any_empty) begin
          commit     = 1'b1;
          commit_way = empty_way;
        end else if (ways_act == CNT_W'(1)) begin
          commit       = 1'b1;
          commit_evict = 1'b1;
        end else begin
          // set is full: walk the stamps for the oldest way
          state_nxt    = ST_SCAN;
          scan_idx_nxt = WAY_W'(1);
          victim_nxt   = '0;
          best_nxt     = rd_line[0].stamp;
        end
      end
      ST_SCAN: begin
        if (scan_last) begin
          commit       = 1'b1;
          commit_evict = 1'b1;
          commit_way   = scan_lt ? scan_idx_r : victim_r;
        end else begin
          scan_idx_nxt = scan_idx_r + WAY_W'(1);
          if (scan_lt) begin
            victim_nxt = scan_idx_r;
            best_nxt   = scan_stamp;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    if (commit) begin
      state_nxt = ST_IDLE;
    end
  end

  // a modify's second lookup always hits the same way: fold it into one write
  always_comb begin
    stamp_new  = clock_r + {30'd0, cur_modify_r, !cur_modify_r};
    hits_new   = hits_r + {31'd0, commit_hit} + {31'd0, cur_modify_r};
    misses_new = misses_r + {31'd0, !commit_hit};
    evicts_new = evicts_r + {31'd0, commit_evict};
    way_ext    = {3'b000, commit_way};
  end

  always_comb begin
    we      = '0;
    wr_addr = cur_set_r;
    wr_data = '{valid: 1'b1, tag: cur_tag_r, stamp: stamp_new};
    if (state_r == ST_CLEAR) begin
      we      = '1;
      wr_addr = row_r;
      wr_data = '0;
    end else if (commit) begin
      we[commit_way] = 1'b1;
    end
  end

  assign res_push = commit;
  always_comb begin
    res_data.first_hit       = commit_hit;
    res_data.evicted         = commit_evict;
    res_data.second_hit      = cur_modify_r;
    res_data.way_used        = way_ext[2:0];
    res_data.hits_total      = hits_new;
    res_data.misses_total    = misses_new;
    res_data.evictions_total = evicts_new;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      row_r      <= '0;
      scan_idx_r <= '0;
      victim_r   <= '0;
      clock_r    <= '0;
      hits_r     <= '0;
      misses_r   <= '0;
      evicts_r   <= '0;
    end else begin
      state_r    <= state_nxt;
      row_r      <= row_nxt;
      scan_idx_r <= scan_idx_nxt;
      victim_r   <= victim_nxt;
      if (commit) begin
        clock_r  <= stamp_new;
        hits_r   <= hits_new;
        misses_r <= misses_new;
        evicts_r <= evicts_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    best_r <= best_nxt;
    if (item_take) begin
      cur_modify_r <= item_modify;
      cur_tag_r    <= item_tag;
      cur_set_r    <= item_set;
    end
  end

endmodule

@@ rtl/core/sacl_res_fifo.sv @@
// ----------------------------------------------------------------------------
// sacl_res_fifo
// Two-entry result queue between the lookup engine and the result port.
// ----------------------------------------------------------------------------
module sacl_res_fifo import sacl_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  res_t push_data,
  output logic full,
  output logic empty,
  input  logic pop,
  output res_t pop_data
);

  logic [1:0] count_r, count_nxt;
  logic       wr_ptr_r, rd_ptr_r;
  res_t       entry_r [2];
  logic       do_pop;

  assign full     = (count_r == 2'd2);
  assign empty    = (count_r == 2'd0);
  assign do_pop   = pop && !empty;
  assign pop_data = entry_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !do_pop) begin
      count_nxt = count_r + 2'd1;
    end else if (!push && do_pop) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= 2'd0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule
